// ===== rtl/core/ffwd_pkg.sv =====
// ----------------------------------------------------------------------------
// ffwd_pkg
// Shared types and constants for the first-free worker dispatch block.
// ----------------------------------------------------------------------------
package ffwd_pkg;

    localparam int TICKET_W   = 16;
    localparam int DUR_W      = 16;
    localparam int WORKER_W   = 5;
    localparam int ACT_W      = 5;
    localparam int MAX_ASSIGN = 64;
    localparam int NCNT_W     = $clog2(MAX_ASSIGN + 1);

    localparam logic FUNC_ENQ     = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;
    localparam logic ST_ASSIGNED  = 1'b0;
    localparam logic ST_DROPPED   = 1'b1;

    typedef struct packed {
        logic [DUR_W-1:0]    duration;
        logic [TICKET_W-1:0] ticket;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [WORKER_W-1:0] worker;
        logic                status;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHK  = 4'b0010,
        S_POP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/ffwd_if.sv =====
// ----------------------------------------------------------------------------
// ffwd job / result channels
// Valid/ready channels carrying input jobs and dispatch results.
// ----------------------------------------------------------------------------
interface ffwd_job_if
    import ffwd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                func;
    logic [DUR_W-1:0]    duration;
    logic [TICKET_W-1:0] ticket;

    modport source (output valid, func, duration, ticket, input ready);
    modport sink   (input valid, func, duration, ticket, output ready);
endinterface

interface ffwd_res_if
    import ffwd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TICKET_W-1:0] ticket_res;
    logic [WORKER_W-1:0] worker;
    logic                status;
    logic                last;

    modport source (output valid, ticket_res, worker, status, last, input ready);
    modport sink   (input valid, ticket_res, worker, status, last, output ready);
    modport mon    (input valid, ready, ticket_res, worker, status, last);
endinterface

// ===== rtl/core/ffwd_ram.sv =====
// ----------------------------------------------------------------------------
// ffwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ffwd_queue.sv =====
// ----------------------------------------------------------------------------
// ffwd_queue
// Job FIFO: RAM storage plus head/tail pointers and fill count.
// ----------------------------------------------------------------------------
module ffwd_queue
    import ffwd_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    input  q_cmd_t  cmd,
    input  job_t    wr_job,
    output q_stat_t stat,
    output job_t    head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [$bits(job_t)-1:0] rdata;

    // head is always presented, so registered read data tracks the head entry in the following cycle
    ffwd_ram #(
        .WIDTH ($bits(job_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (wr_job),
        .raddr (head_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
        end
        if (cmd.pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        if (cmd.push && !cmd.pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop && !cmd.push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = job_t'(rdata);

endmodule

// ===== rtl/core/ffwd_pool.sv =====
// ----------------------------------------------------------------------------
// ffwd_pool
// Worker remaining-time store: RAM with per-entry valid bits so that
// entries read as idle until first written after reset.
// ----------------------------------------------------------------------------
module ffwd_pool
    import ffwd_pkg::*;
#(
    parameter int WORKERS = 16,
    localparam int WW     = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WW-1:0]    rd_addr,
    input  logic             we,
    input  logic [WW-1:0]    wr_addr,
    input  logic [DUR_W-1:0] wr_data,
    output logic [DUR_W-1:0] rem
);

    logic [WORKERS-1:0] vld_reg;
    logic               rd_vld_reg;
    logic [DUR_W-1:0]   rdata;

    ffwd_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WORKERS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rem = rd_vld_reg ? rdata : '0;

endmodule

// ===== rtl/core/first_free_worker_dispatch.sv =====
// ----------------------------------------------------------------------------
// first_free_worker_dispatch
// Job FIFO feeding a pool of workers; each tick hands up to MAX_ASSIGN queued jobs to idle
// active workers in index order and ages every busy worker by one.
// ----------------------------------------------------------------------------
// Enqueue: push; on a full queue the job is dropped and S_FIN moves its result from the
//   hold stage to the output register once the output is free. Tick: walks all
//   MAX_WORKERS worker entries, one pop per assignment; no item is taken until it ends.
// Results leave through a one-deep hold stage and an output register.
// Reset: queue pointers, count, worker valid bits and control clear at once;
//   queue memory is not cleared, active_workers resets to 1.
module first_free_worker_dispatch
    import ffwd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int MAX_WORKERS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [ACT_W-1:0] cfg_wdata,
    ffwd_job_if.sink         job,
    ffwd_res_if.source       res
);

    localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NWW = $clog2(MAX_WORKERS + 1);

    state_t             state_reg, state_next;
    logic [WW-1:0]      w_reg, w_next;
    logic [NCNT_W-1:0]  n_reg, n_next;
    logic [NWW-1:0]     nw_reg, nw_next;
    logic [DUR_W-1:0]   rem_reg, rem_next;
    logic               use_ram_reg, use_ram_next;
    logic               hold_valid_reg, hold_valid_next;
    res_t               hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;
    logic               out_last_reg, out_last_next;
    logic [ACT_W-1:0]   act_reg;

    q_cmd_t             q_cmd;
    q_stat_t            q_stat;
    job_t               head_job;
    job_t               wr_job;
    logic [WW-1:0]      pool_rd_addr;
    logic               pool_we;
    logic [DUR_W-1:0]   pool_wr_data;
    logic [DUR_W-1:0]   pool_rem;

    logic               accept;
    logic               out_free;
    logic               can_emit;
    logic               eligible;
    logic               last_worker;
    logic [DUR_W-1:0]   cur_rem;
    logic [WW:0]        wnum;

    ffwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_cmd),
        .wr_job   (wr_job),
        .stat     (q_stat),
        .head_job (head_job)
    );

    ffwd_pool #(
        .WORKERS (MAX_WORKERS)
    ) u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (pool_rd_addr),
        .we      (pool_we),
        .wr_addr (w_reg),
        .wr_data (pool_wr_data),
        .rem     (pool_rem)
    );

    assign accept          = job.valid && job.ready;
    assign wr_job.duration = job.duration;
    assign wr_job.ticket   = job.ticket;

    assign out_free    = !out_valid_reg || res.ready;
    assign can_emit    = !hold_valid_reg || out_free;
    assign cur_rem     = use_ram_reg ? pool_rem : rem_reg;
    assign last_worker = (w_reg == WW'(MAX_WORKERS - 1));
    assign wnum        = (WW + 1)'(w_reg) + (WW + 1)'(1);
    assign eligible    = (NWW'(w_reg) < nw_reg) && (cur_rem == '0) && !q_stat.empty
                         && (n_reg < NCNT_W'(MAX_ASSIGN));

    // prefetch the next worker entry while the current one is written back
    assign pool_rd_addr = (state_reg == S_CHK) ? w_reg + WW'(1) : '0;
    assign pool_we      = (state_reg == S_CHK) && !eligible;
    assign pool_wr_data = (cur_rem == '0) ? '0 : cur_rem - DUR_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        nw_next         = nw_reg;
        rem_next        = rem_reg;
        use_ram_next    = use_ram_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = res.ready ? 1'b0 : out_valid_reg;
        q_cmd.push      = 1'b0;
        q_cmd.pop       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (job.func == FUNC_TICK)
                    begin
                        w_next       = '0;
                        n_next       = '0;
                        use_ram_next = 1'b1;
                        nw_next      = (int'(act_reg) > MAX_WORKERS) ? NWW'(MAX_WORKERS)
                                                                     : NWW'(act_reg);
                        state_next   = S_CHK;
                    end
                    else if (q_stat.full)
                    begin
                        hold_valid_next  = 1'b1;
                        hold_next.ticket = job.ticket;
                        hold_next.worker = '0;
                        hold_next.status = ST_DROPPED;
                        state_next       = S_FIN;
                    end
                    else
                    begin
                        q_cmd.push = 1'b1;
                    end
                end
            end
            S_CHK:
            begin
                if (eligible)
                begin
                    state_next = S_POP;
                end
                else if (last_worker)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    w_next       = w_reg + WW'(1);
                    use_ram_next = 1'b1;
                end
            end
            S_POP:
            begin
                // the previous result is known not to be last once another one follows
                if (can_emit)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    hold_valid_next  = 1'b1;
                    hold_next.ticket = head_job.ticket;
                    hold_next.worker = WORKER_W'(wnum);
                    hold_next.status = ST_ASSIGNED;
                    q_cmd.pop        = 1'b1;
                    n_next           = n_reg + NCNT_W'(1);
                    rem_next         = head_job.duration;
                    use_ram_next     = 1'b0;
                    state_next       = S_CHK;
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            w_reg          <= '0;
            n_reg          <= '0;
            nw_reg         <= '0;
            use_ram_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            act_reg        <= ACT_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            w_reg          <= w_next;
            n_reg          <= n_next;
            nw_reg         <= nw_next;
            use_ram_reg    <= use_ram_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                act_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign job.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.ticket_res = out_reg.ticket;
    assign res.worker     = out_reg.worker;
    assign res.status     = out_reg.status;
    assign res.last       = out_last_reg;

endmodule

// ===== rtl/core/ffwd_chk.sv =====
// ----------------------------------------------------------------------------
// ffwd_chk
// Port-level checks on the dispatch result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ffwd_chk
    import ffwd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                valid,
    input logic                ready,
    input logic [TICKET_W-1:0] ticket_res,
    input logic [WORKER_W-1:0] worker,
    input logic                status,
    input logic                last
);

    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(ticket_res)
        && $stable(worker) && $stable(status) && $stable(last))
        else $error("result transaction changed while stalled");

    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_DROPPED |-> last)
        else $error("dropped-job result not marked last");

    a_drop_worker: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_DROPPED |-> worker == '0)
        else $error("dropped-job result carries a worker number");

    a_assign_worker: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_ASSIGNED |-> worker != '0)
        else $error("assignment result with worker zero");

endmodule

bind first_free_worker_dispatch ffwd_chk u_ffwd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (res.valid),
    .ready      (res.ready),
    .ticket_res (res.ticket_res),
    .worker     (res.worker),
    .status     (res.status),
    .last       (res.last)
);
